### sv/lmfs_pkg.sv
// Shared types, codes and constants of the frame store serializer.
package lmfs_pkg;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_DRAW   = 2'd0;
   localparam logic [1:0] REQ_COLOUR = 2'd1;
   localparam logic [1:0] REQ_FRAME  = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   // Pixel draw modes; the fourth code leaves the pixel alone.
   localparam logic [1:0] DRAW_SET   = 2'd0;
   localparam logic [1:0] DRAW_CLEAR = 2'd1;
   localparam logic [1:0] DRAW_FLIP  = 2'd2;

   // Message kinds held while a message is shifted out.
   localparam logic KIND_COLOUR = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   // Frame store geometry and message layout.
   localparam int FRAME_BYTES  = 256;
   localparam int FRAME_ADDR_W = $clog2(FRAME_BYTES);
   localparam int BYTE_INDEX_W = 9;
   localparam logic [BYTE_INDEX_W-1:0] COLOUR_MSG_LEN = 9'd5;
   localparam logic [BYTE_INDEX_W-1:0] FRAME_MSG_LEN  = 9'(FRAME_BYTES + 4);
   localparam logic [BYTE_INDEX_W-1:0] FRAME_FIRST    = 9'd3;
   localparam logic [BYTE_INDEX_W-1:0] FRAME_END      = 9'(FRAME_BYTES + 3);

   // Protocol bytes.
   localparam logic [7:0] HDR_COLOUR = 8'h42;
   localparam logic [7:0] TRAILER    = 8'h43;
   localparam logic [7:0] HDR_FRAME  = 8'h47;
   localparam logic [7:0] FRAME_ARG1 = 8'h7F;
   localparam logic [7:0] FRAME_ARG2 = 8'hFF;
   localparam logic [7:0] PIXEL_BIT0 = 8'h80;

   // Reset value of the half-bit tick count register.
   localparam logic [7:0] HALF_BIT_RESET = 8'd2;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte offset of each group of eight rows within a column.
   localparam logic [1:0] ROW_BLOCK_MAP [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

   // One input item.
   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] pixel_x;
      logic [4:0] pixel_y;
      logic [1:0] draw_mode;
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } lmfs_req_type;

   // One result item.
   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic busy_res;
      logic rejected;
   } lmfs_rsp_type;

   // A classified request as it travels through the queue.
   typedef struct packed {
      logic [1:0]              code;
      logic [FRAME_ADDR_W-1:0] pos;
      logic [7:0]              mask;
      logic [1:0]              mode;
      logic [6:0]              red;
      logic [6:0]              green;
      logic [6:0]              blue;
   } lmfs_cmd_type;

endpackage

### sv/lmfs_front.sv
// Front part: classifies a request and works out its frame store byte and bit.
module lmfs_front (
   input  lmfs_pkg::lmfs_req_type req_data,
   output lmfs_pkg::lmfs_cmd_type cmd
);

   // Byte is the row block offset plus four times the column; bit is MSB first.
   always_comb begin
      cmd.code  = req_data.req_type;
      cmd.pos   = {req_data.pixel_x, lmfs_pkg::ROW_BLOCK_MAP[req_data.pixel_y[4:3]]};
      cmd.mask  = lmfs_pkg::PIXEL_BIT0 >> req_data.pixel_y[2:0];
      cmd.mode  = req_data.draw_mode;
      cmd.red   = req_data.red_level[7:1];
      cmd.green = req_data.green_level[7:1];
      cmd.blue  = req_data.blue_level[7:1];
   end

endmodule

### sv/lmfs_queue.sv
// Short queue of classified requests between the front and back parts.
module lmfs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lmfs_pkg::lmfs_cmd_type in_cmd,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lmfs_pkg::lmfs_cmd_type out_cmd
);

   lmfs_pkg::lmfs_cmd_type entry_ff [lmfs_pkg::QUEUE_DEPTH];
   logic [lmfs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lmfs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lmfs_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   // Handshake on both sides.
   assign in_ready  = (count_ff < lmfs_pkg::QUEUE_CNT_W'(lmfs_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lmfs_pkg::QUEUE_PTR_W'(lmfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lmfs_pkg::QUEUE_PTR_W'(lmfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

### sv/lmfs_back.sv
// Back part: frame store, serial sender state and the result register.
module lmfs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  lmfs_pkg::lmfs_cmd_type cmd,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lmfs_pkg::lmfs_rsp_type rsp_data
);

   localparam int AW = lmfs_pkg::FRAME_ADDR_W;
   localparam int BW = lmfs_pkg::BYTE_INDEX_W;

   // Frame store memory with one valid bit per byte; an unwritten byte reads as zero.
   logic [7:0]             mem [lmfs_pkg::FRAME_BYTES];
   logic [lmfs_pkg::FRAME_BYTES-1:0] valid_ff;

   // Execute stage holding one request and its frame store byte.
   logic                   exec_valid_ff, exec_valid_in;
   lmfs_pkg::lmfs_cmd_type exec_cmd_ff;
   logic [7:0]             rd1_data_ff;
   logic                   rd1_valid_ff;
   logic                   fwd_hit_ff;
   logic [7:0]             fwd_byte_ff;

   // Sender read port, addressed by the next byte index.
   logic [7:0]             rd2_data_ff;
   logic                   rd2_valid_ff;
   logic [BW-1:0]          rd2_diff;
   logic [AW-1:0]          rd2_addr;

   // Sender state.
   logic                   sending_ff, sending_in;
   logic                   kind_ff, kind_in;
   logic [BW-1:0]          byte_index_ff, byte_index_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic                   half_ff, half_in;
   logic [7:0]             tick_ff, tick_in;
   logic                   clock_level_ff, clock_level_in;
   logic                   data_level_ff, data_level_in;
   logic [6:0]             colour_ff [3];
   logic [7:0]             half_bit_ticks_ff;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   lmfs_pkg::lmfs_rsp_type rsp_data_ff, rsp_data_in;

   logic                   exec_fire;
   logic                   load;
   logic                   wr_en;
   logic [7:0]             wr_data;
   logic                   fwd_hit_in;
   logic [7:0]             old_byte;
   logic [7:0]             frame_byte;
   logic [7:0]             msg_byte;

   // Stage handshakes: execute moves when the result register is free or drains.
   assign exec_fire     = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready     = !exec_valid_ff || exec_fire;
   assign load          = cmd_valid && cmd_ready;
   assign exec_valid_in = load || (exec_valid_ff && !exec_fire);
   assign rsp_valid_in  = exec_fire || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   // A write in execute to the byte being read for the next request is forwarded.
   assign fwd_hit_in = exec_fire && wr_en && (exec_cmd_ff.pos == cmd.pos);
   assign old_byte   = fwd_hit_ff ? fwd_byte_ff : (rd1_valid_ff ? rd1_data_ff : 8'h00);
   assign frame_byte = rd2_valid_ff ? rd2_data_ff : 8'h00;

   // Byte of the current message at the current byte index.
   always_comb begin
      if (kind_ff == lmfs_pkg::KIND_COLOUR) begin
         case (byte_index_ff)
            9'd0:    msg_byte = lmfs_pkg::HDR_COLOUR;
            9'd1:    msg_byte = {1'b0, colour_ff[0]};
            9'd2:    msg_byte = {1'b0, colour_ff[1]};
            9'd3:    msg_byte = {1'b0, colour_ff[2]};
            default: msg_byte = lmfs_pkg::TRAILER;
         endcase
      end else begin
         case (byte_index_ff)
            9'd0:    msg_byte = lmfs_pkg::HDR_FRAME;
            9'd1:    msg_byte = lmfs_pkg::FRAME_ARG1;
            9'd2:    msg_byte = lmfs_pkg::FRAME_ARG2;
            default: begin
               msg_byte = (byte_index_ff < lmfs_pkg::FRAME_END) ? frame_byte
                                                                : lmfs_pkg::TRAILER;
            end
         endcase
      end
   end

   // Execute one request: draw, start a message, or advance the sender by one tick.
   always_comb begin
      logic [7:0]    limit;
      logic [8:0]    tick_next;
      logic [BW-1:0] byte_next;
      logic [BW-1:0] msg_len;
      limit          = (half_bit_ticks_ff == 8'd0) ? 8'd1 : half_bit_ticks_ff;
      tick_next      = {1'b0, tick_ff} + 9'd1;
      byte_next      = byte_index_ff + 1'b1;
      msg_len        = (kind_ff == lmfs_pkg::KIND_FRAME) ? lmfs_pkg::FRAME_MSG_LEN
                                                         : lmfs_pkg::COLOUR_MSG_LEN;
      sending_in     = sending_ff;
      kind_in        = kind_ff;
      byte_index_in  = byte_index_ff;
      bit_index_in   = bit_index_ff;
      half_in        = half_ff;
      tick_in        = tick_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      wr_en          = 1'b0;
      wr_data        = old_byte;
      rsp_data_in.clock_line = clock_level_ff;
      rsp_data_in.data_line  = data_level_ff;
      rsp_data_in.rejected   = 1'b0;
      if (exec_fire) begin
         if (exec_cmd_ff.code == lmfs_pkg::REQ_TICK) begin
            if (sending_ff) begin
               if (!half_ff) begin
                  data_level_in  = msg_byte[3'd7 - bit_index_ff];
                  clock_level_in = 1'b0;
               end else begin
                  clock_level_in = 1'b1;
               end
               rsp_data_in.clock_line = clock_level_in;
               rsp_data_in.data_line  = data_level_in;
               if (tick_next < {1'b0, limit}) begin
                  tick_in = tick_next[7:0];
               end else begin
                  tick_in = 8'd0;
                  if (!half_ff) begin
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     if (bit_index_ff != 3'd7) begin
                        bit_index_in = bit_index_ff + 1'b1;
                     end else begin
                        bit_index_in  = 3'd0;
                        data_level_in = 1'b1;
                        byte_index_in = byte_next;
                        if (byte_next >= msg_len) begin
                           byte_index_in  = '0;
                           sending_in     = 1'b0;
                           clock_level_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end else if (sending_ff) begin
            rsp_data_in.rejected = 1'b1;
         end else begin
            case (exec_cmd_ff.code)
               lmfs_pkg::REQ_DRAW: begin
                  case (exec_cmd_ff.mode)
                     lmfs_pkg::DRAW_SET: begin
                        wr_en   = 1'b1;
                        wr_data = old_byte | exec_cmd_ff.mask;
                     end
                     lmfs_pkg::DRAW_CLEAR: begin
                        wr_en   = 1'b1;
                        wr_data = old_byte & ~exec_cmd_ff.mask;
                     end
                     lmfs_pkg::DRAW_FLIP: begin
                        wr_en   = 1'b1;
                        wr_data = old_byte ^ exec_cmd_ff.mask;
                     end
                     default: wr_en = 1'b0;
                  endcase
               end
               lmfs_pkg::REQ_COLOUR, lmfs_pkg::REQ_FRAME: begin
                  kind_in       = (exec_cmd_ff.code == lmfs_pkg::REQ_FRAME) ?
                                  lmfs_pkg::KIND_FRAME : lmfs_pkg::KIND_COLOUR;
                  byte_index_in = '0;
                  bit_index_in  = 3'd0;
                  half_in       = 1'b0;
                  tick_in       = 8'd0;
                  sending_in    = 1'b1;
               end
               default: wr_en = 1'b0;
            endcase
         end
      end
      rsp_data_in.busy_res = sending_in;
   end

   // The sender port prefetches the frame byte for the next byte index.
   assign rd2_diff = byte_index_in - lmfs_pkg::FRAME_FIRST;
   assign rd2_addr = rd2_diff[AW-1:0];

   // Frame store memory: one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[exec_cmd_ff.pos] <= wr_data;
      end
      if (load) begin
         rd1_data_ff <= mem[cmd.pos];
      end
      rd2_data_ff <= mem[rd2_addr];
   end

   // Valid bits and their registered reads; reset empties the frame store at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd1_valid_ff <= 1'b0;
         rd2_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[exec_cmd_ff.pos] <= 1'b1;
         end
         if (load) begin
            rd1_valid_ff <= valid_ff[cmd.pos];
         end
         rd2_valid_ff <= valid_ff[rd2_addr];
      end
   end

   // Execute stage payload and forwarding capture.
   always_ff @(posedge clock) begin
      if (load) begin
         exec_cmd_ff <= cmd;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_byte_ff <= wr_data;
      end
      if (exec_fire && !sending_ff && (exec_cmd_ff.code == lmfs_pkg::REQ_COLOUR)) begin
         colour_ff[0] <= exec_cmd_ff.red;
         colour_ff[1] <= exec_cmd_ff.green;
         colour_ff[2] <= exec_cmd_ff.blue;
      end
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Control and sender state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         sending_ff        <= 1'b0;
         kind_ff           <= lmfs_pkg::KIND_COLOUR;
         byte_index_ff     <= '0;
         bit_index_ff      <= 3'd0;
         half_ff           <= 1'b0;
         tick_ff           <= 8'd0;
         clock_level_ff    <= 1'b1;
         data_level_ff     <= 1'b1;
         half_bit_ticks_ff <= lmfs_pkg::HALF_BIT_RESET;
      end else begin
         exec_valid_ff  <= exec_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         sending_ff     <= sending_in;
         kind_ff        <= kind_in;
         byte_index_ff  <= byte_index_in;
         bit_index_ff   <= bit_index_in;
         half_ff        <= half_in;
         tick_ff        <= tick_in;
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
         if (csr_write_enable) begin
            half_bit_ticks_ff <= csr_write_data;
         end
      end
   end

endmodule

### sv/led_matrix_framebuffer_serializer.sv
// Top level of the 64x32 monochrome frame store with its two-wire serial sender.
//
// Requests arrive on the req_ channel (valid/ready); every accepted request gives
// exactly one result on the rsp_ channel, in order. A draw sets, clears or inverts
// one pixel, a colour or frame request starts a message, and a tick advances the
// serial sender by one step. Results carry the clock and data line levels, busy
// and a flag for requests refused while a message is in flight.
// While the receiver does not stall, one request per cycle is sustained, set by the
// single execute stage that updates the sender state and does the frame store
// read-modify-write (with forwarding between neighboring draws). A two-entry queue
// separates the classifying front from the executing back. When the receiver
// stalls, the result register holds, the execute stage and then the queue fill,
// and req_ready falls; nothing is lost. Reset is synchronous: the frame store
// reads as all zeros at once through its valid bits, so no clearing pass is
// needed, both lines idle high and the tick count per clock half returns to two.
// csr_write_enable writes that count; the user must use it only while the block
// is idle, and the block itself does not enforce this.
module led_matrix_framebuffer_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lmfs_pkg::lmfs_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lmfs_pkg::lmfs_rsp_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data
);

   lmfs_pkg::lmfs_cmd_type front_cmd;
   lmfs_pkg::lmfs_cmd_type queue_cmd;
   logic                   queue_valid;
   logic                   queue_ready;

   // Classify each request.
   lmfs_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   // Queue between the front and back parts.
   lmfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   // Execute requests and produce results.
   lmfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_valid),
      .cmd_ready        (queue_ready),
      .cmd              (queue_cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

### tb/lmfs_line_check_pkg.sv
// Line-level predictor and scoreboard for the frame store serializer testbench.
`timescale 1ns / 100ps
package lmfs_line_check_pkg;
   import lmfs_pkg::*;

   // Bytes that frame each serial message.
   localparam logic [7:0] COLOUR_HEADER   = 8'h42;
   localparam logic [7:0] MESSAGE_TRAILER = 8'h43;
   localparam logic [7:0] FRAME_HEADER    = 8'h47;
   localparam logic [7:0] FRAME_WINDOW_A  = 8'h7F;
   localparam logic [7:0] FRAME_WINDOW_B  = 8'hFF;

   localparam int          STORE_BYTES      = 256;
   localparam int          COLOUR_MSG_BYTES = 5;
   localparam int          FRAME_MSG_BYTES  = STORE_BYTES + 4;
   localparam logic [7:0]  HALF_TICKS_RESET = 8'd2;

   class line_scoreboard;
      // Copy of the block state, advanced once per accepted request.
      logic [7:0]  pixels [STORE_BYTES];
      logic [6:0]  colour_levels [3];
      logic        message_kind;
      int unsigned byte_pos;
      logic [2:0]  bit_pos;
      logic        high_half;
      logic [7:0]  half_count;
      logic        sending;
      logic        clock_level;
      logic        data_level;
      logic [7:0]  half_ticks;

      // Line levels still owed by the block, oldest first.
      lmfs_rsp_type expected_lines [$];

      int unsigned failures;
      int unsigned results_checked;
      int unsigned colour_messages;
      int unsigned frame_messages;
      int unsigned refused;
      int unsigned shifted_ticks;

      function new();
         foreach (pixels[i]) pixels[i] = 8'h00;
         foreach (colour_levels[i]) colour_levels[i] = 7'h00;
         message_kind = KIND_COLOUR;
         byte_pos = 0;
         bit_pos = 3'd0;
         high_half = 1'b0;
         half_count = 8'd0;
         sending = 1'b0;
         clock_level = 1'b1;
         data_level = 1'b1;
         half_ticks = HALF_TICKS_RESET;
         failures = 0;
         results_checked = 0;
         colour_messages = 0;
         frame_messages = 0;
         refused = 0;
         shifted_ticks = 0;
      endfunction

      function void set_half_ticks(logic [7:0] value);
         half_ticks = value;
      endfunction

      function int unsigned pending();
         return expected_lines.size();
      endfunction

      function logic is_sending();
         return sending;
      endfunction

      function int unsigned message_length();
         return (message_kind == KIND_FRAME) ? FRAME_MSG_BYTES : COLOUR_MSG_BYTES;
      endfunction

      // Byte of the current message at the current byte position.
      function logic [7:0] message_byte();
         if (message_kind == KIND_COLOUR) begin
            if (byte_pos == 0) return COLOUR_HEADER;
            if (byte_pos <= 3) return {1'b0, colour_levels[byte_pos - 1]};
            return MESSAGE_TRAILER;
         end
         if (byte_pos == 0) return FRAME_HEADER;
         if (byte_pos == 1) return FRAME_WINDOW_A;
         if (byte_pos == 2) return FRAME_WINDOW_B;
         if (byte_pos < STORE_BYTES + 3) return pixels[byte_pos - 3];
         return MESSAGE_TRAILER;
      endfunction

      function void begin_message(logic kind);
         message_kind = kind;
         byte_pos = 0;
         bit_pos = 3'd0;
         high_half = 1'b0;
         half_count = 8'd0;
         sending = 1'b1;
      endfunction

      // One tick of the serial sender; returns the levels driven during it.
      function void shift_tick(output logic clk_out, output logic dat_out);
         logic [7:0] limit;
         logic [7:0] current;
         limit = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
         if (!high_half) begin
            current = message_byte();
            data_level = current[3'd7 - bit_pos];
            clock_level = 1'b0;
         end else begin
            clock_level = 1'b1;
         end
         clk_out = clock_level;
         dat_out = data_level;
         half_count = half_count + 8'd1;
         if (half_count < limit) return;
         half_count = 8'd0;
         if (!high_half) begin
            high_half = 1'b1;
            return;
         end
         high_half = 1'b0;
         if (bit_pos != 3'd7) begin
            bit_pos = bit_pos + 3'd1;
            return;
         end
         // The data line goes back high between bytes.
         bit_pos = 3'd0;
         data_level = 1'b1;
         byte_pos++;
         if (byte_pos >= message_length()) begin
            byte_pos = 0;
            sending = 1'b0;
            clock_level = 1'b1;
         end
      endfunction

      // Called on every request transfer: predicts the line levels it yields.
      function void note_request(lmfs_req_type req);
         lmfs_rsp_type lines;
         logic         clk;
         logic         dat;
         logic [7:0]   mask;
         logic [7:0]   addr;
         clk = clock_level;
         dat = data_level;
         lines.rejected = 1'b0;
         if (req.req_type == REQ_TICK) begin
            if (sending) begin
               shift_tick(clk, dat);
               shifted_ticks++;
            end
         end else if (sending) begin
            lines.rejected = 1'b1;
            refused++;
         end else begin
            case (req.req_type)
               REQ_DRAW: begin
                  // Row groups of eight swap in pairs within each column.
                  mask = 8'h80 >> req.pixel_y[2:0];
                  addr = {req.pixel_x, req.pixel_y[4:3] ^ 2'b01};
                  case (req.draw_mode)
                     DRAW_SET:   pixels[addr] = pixels[addr] | mask;
                     DRAW_CLEAR: pixels[addr] = pixels[addr] & ~mask;
                     DRAW_FLIP:  pixels[addr] = pixels[addr] ^ mask;
                     default: ;
                  endcase
               end
               REQ_COLOUR: begin
                  colour_levels[0] = req.red_level[7:1];
                  colour_levels[1] = req.green_level[7:1];
                  colour_levels[2] = req.blue_level[7:1];
                  begin_message(KIND_COLOUR);
                  colour_messages++;
               end
               default: begin
                  begin_message(KIND_FRAME);
                  frame_messages++;
               end
            endcase
         end
         lines.clock_line = clk;
         lines.data_line = dat;
         lines.busy_res = sending;
         expected_lines.push_back(lines);
      endfunction

      function void compare_field(string name, logic want, logic got);
         if (got !== want) begin
            failures++;
            $display("%0t: result %0d field %s expected %b actual %b",
                     $time, results_checked, name, want, got);
         end
      endfunction

      // Called on every result transfer: compares it with the oldest prediction.
      function void check_response(lmfs_rsp_type got);
         lmfs_rsp_type want;
         if (expected_lines.size() == 0) begin
            failures++;
            $display("%0t: unexpected result expected none actual %b", $time, got);
            return;
         end
         want = expected_lines.pop_front();
         results_checked++;
         compare_field("clock_line", want.clock_line, got.clock_line);
         compare_field("data_line", want.data_line, got.data_line);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("rejected", want.rejected, got.rejected);
      endfunction
   endclass

endpackage

### tb/led_matrix_framebuffer_serializer_test.sv
// Top-level testbench of the frame store serializer: stimulus, pacing and checking.
`timescale 1ns / 100ps
module led_matrix_framebuffer_serializer_test;
   import lmfs_pkg::*;
   import lmfs_line_check_pkg::*;

   localparam logic [1:0] MODE_IGNORED    = 2'd3;
   localparam int         LIMIT_CYCLES    = 100_000;
   localparam int         HOLD_CYCLES     = 400;
   localparam int         PHASE_REQUESTS  = 80;
   localparam int         SLOW_HALF_TICKS = 12;
   localparam int         FRAME_TICKS     = 90;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   lmfs_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lmfs_rsp_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data = 8'd0;

   line_scoreboard board = new();

   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int          burst_left = 0;
   int          steady_left = 0;
   int unsigned settings_written = 0;
   int unsigned cycle_count = 0;

   led_matrix_framebuffer_serializer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Receiver: changing stall styles, plus a long hold when the sequence asks for one.
   initial begin
      int          hold_left;
      int          style;
      int          style_left;
      logic [31:0] pattern;
      int          pattern_pos;
      hold_left = 0;
      style = 0;
      style_left = 0;
      pattern = 32'hFFFF_FFFF;
      pattern_pos = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 3);
               style_left = $urandom_range(20, 120);
               pattern = $urandom;
            end
            style_left--;
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= pattern[pattern_pos % 32];
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            pattern_pos++;
         end
      end
   end

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (steady_left > 0) begin
         steady_left--;
         return;
      end
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 47);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   // Offers one request and holds it until the transfer.
   task automatic offer(input lmfs_req_type req);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(req);
      pace_sender();
   endtask

   function automatic lmfs_req_type random_fields();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(lmfs_req_type)-1:0];
   endfunction

   function automatic lmfs_req_type make_request(logic [1:0] code);
      lmfs_req_type req;
      req = random_fields();
      req.req_type = code;
      return req;
   endfunction

   function automatic lmfs_req_type make_draw(logic [5:0] x, logic [4:0] y, logic [1:0] mode);
      lmfs_req_type req;
      req = '0;
      req.req_type = REQ_DRAW;
      req.pixel_x = x;
      req.pixel_y = y;
      req.draw_mode = mode;
      return req;
   endfunction

   function automatic lmfs_req_type make_colour(logic [7:0] red, logic [7:0] green,
                                                logic [7:0] blue);
      lmfs_req_type req;
      req = '0;
      req.req_type = REQ_COLOUR;
      req.red_level = red;
      req.green_level = green;
      req.blue_level = blue;
      return req;
   endfunction

   // While a message is out, mostly ticks with a few refused requests mixed in.
   // While idle, frame messages are left out.
   function automatic lmfs_req_type random_request();
      lmfs_req_type req;
      int unsigned  pick;
      req = random_fields();
      pick = $urandom_range(0, 99);
      if (board.is_sending()) begin
         if (pick < 88) req.req_type = REQ_TICK;
         else if (pick % 3 == 0) req.req_type = REQ_DRAW;
         else if (pick % 3 == 1) req.req_type = REQ_COLOUR;
         else req.req_type = REQ_FRAME;
      end else if (pick < 50) begin
         req.req_type = REQ_DRAW;
      end else if (pick < 72) begin
         req.req_type = REQ_COLOUR;
      end else begin
         req.req_type = REQ_TICK;
      end
      return req;
   endfunction

   task automatic finish_message();
      while (board.is_sending()) offer(make_request(REQ_TICK));
   endtask

   // Stops offering and waits for every owed result.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Drains the sender and waits for every owed result.
   task automatic settle();
      finish_message();
      drain();
   endtask

   task automatic write_half_ticks(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_half_ticks(value);
      settings_written++;
   endtask

   // Directed part at the reset half-bit setting.
   task automatic run_directed();
      offer(make_request(REQ_TICK));
      offer(make_draw(6'd0, 5'd0, DRAW_SET));
      offer(make_draw(6'd63, 5'd31, DRAW_SET));
      offer(make_draw(6'd63, 5'd0, DRAW_SET));
      offer(make_draw(6'd0, 5'd31, DRAW_SET));
      offer(make_draw(6'd0, 5'd0, DRAW_FLIP));
      offer(make_draw(6'd10, 5'd13, DRAW_FLIP));
      offer(make_draw(6'd63, 5'd31, DRAW_CLEAR));
      offer(make_draw(6'd5, 5'd5, MODE_IGNORED));
      offer(make_draw(6'd31, 5'd8, DRAW_SET));
      offer(make_draw(6'd32, 5'd23, DRAW_SET));
      offer(make_draw(6'd1, 5'd7, DRAW_SET));
      offer(make_draw(6'd2, 5'd15, DRAW_SET));
      offer(make_draw(6'd3, 5'd16, DRAW_SET));
      offer(make_draw(6'd4, 5'd24, DRAW_SET));
      offer(make_draw(6'd0, 5'd9, DRAW_SET));
      offer(make_colour(8'hFF, 8'h00, 8'h81));
      // Requests while busy must be refused and leave the state alone.
      offer(make_draw(6'd7, 5'd7, DRAW_SET));
      offer(make_colour(8'h12, 8'h34, 8'h56));
      offer(make_request(REQ_FRAME));
      finish_message();
      offer(make_draw(6'd9, 5'd9, DRAW_SET));
      settle();
   endtask

   // Sends the opening bytes of a frame message, headers and first store bytes.
   task automatic run_frame_start();
      offer(make_request(REQ_FRAME));
      offer(make_colour(8'h7F, 8'h80, 8'hFE));
      offer(make_draw(6'd0, 5'd9, DRAW_CLEAR));
      repeat (FRAME_TICKS) offer(make_request(REQ_TICK));
      drain();
   endtask

   // Main sequence.
   initial begin
      int half_plan [5];
      int half_value;
      half_plan = '{1, 0, 255, -1, 1};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      run_directed();

      foreach (half_plan[i]) begin
         half_value = (half_plan[i] < 0) ? $urandom_range(3, 4) : half_plan[i];
         write_half_ticks(half_value[7:0]);
         if (i == 0) begin
            // Long receiver hold while the sender keeps offering items back to back.
            hold_requests++;
            steady_left = 80;
         end
         repeat (PHASE_REQUESTS) offer(random_request());
         // A message at very long clock halves is sped up once the block is empty.
         if (board.is_sending() && half_value > SLOW_HALF_TICKS) begin
            drain();
            write_half_ticks(8'd1);
         end
         settle();
      end

      run_frame_start();

      repeat (8) @(posedge clock);
      $display("Checked %0d results over %0d colour and %0d frame messages, %0d sender ticks.",
               board.results_checked, board.colour_messages, board.frame_messages,
               board.shifted_ticks);
      $display("%0d requests refused while busy, %0d half-bit settings, %0d long receiver hold.",
               board.refused, settings_written, hold_requests);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

### led_matrix_framebuffer_serializer.f
sv/lmfs_pkg.sv
sv/lmfs_front.sv
sv/lmfs_queue.sv
sv/lmfs_back.sv
sv/led_matrix_framebuffer_serializer.sv
tb/lmfs_line_check_pkg.sv
tb/led_matrix_framebuffer_serializer_test.sv
